[hdl/lpl_pkg.sv]
// Shared types, constants and helper functions of the lookahead peak limiter.
package lpl_pkg;

  localparam int SMP_W      = 24;
  localparam int GAIN_W     = 24;
  localparam int COEF_W     = 16;
  localparam int LEN_REG_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // True peak interpolation: OVS points per interval, denominator 2*OVS^3 = 2^TP_SHIFT.
  localparam int OVS      = 4;
  localparam int S_W      = 2;
  localparam int TP_SHIFT = 7;
  localparam int NUM_W    = 36;
  localparam int PEAK_W   = 26;
  localparam int QUO_W    = 23;
  localparam int DCNT_W   = 5;

  localparam logic [GAIN_W-1:0] UNITY_GAIN    = 24'd4194304;
  localparam logic [GAIN_W-1:0] RST_THRESHOLD = 24'd4194304;
  localparam logic [GAIN_W-1:0] RST_CEILING   = 24'd4194304;
  localparam logic [COEF_W-1:0] RST_ATTACK    = 16'd0;
  localparam logic [COEF_W-1:0] RST_RELEASE   = 16'd65000;
  localparam logic [LEN_REG_W-1:0] RST_LEN    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_CEILING   = 3'd1,
    CFG_ATTACK    = 3'd2,
    CFG_RELEASE   = 3'd3,
    CFG_LOOKAHEAD = 3'd4,
    CFG_STEREO    = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_TPGO, S_TP,
    S_DIVGO, S_DIV, S_SM1, S_SM2, S_MUL, S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    TAG_PEAK, TAG_DL, TAG_Y2, TAG_Y3
  } rd_tag_t;

  typedef struct packed {
    logic wr_en;
    logic acc_clr;
    logic acc_en;
  } lane_ctl_t;

  function automatic logic [SMP_W-1:0] mag24(input logic signed [SMP_W-1:0] x);
    logic [SMP_W-1:0] m;
    m = x[SMP_W-1] ? SMP_W'(-x) : SMP_W'(x);
    return m;
  endfunction

  // Round a sample*gain product back to Q1.23 and saturate.
  function automatic logic signed [SMP_W-1:0] gain_sat(input logic signed [48:0] p);
    logic signed [48:0] q;
    q = (p + 49'sd2097152) >>> 22;
    if (q > 49'sd8388607) return 24'sh7fffff;
    if (q < -49'sd8388608) return 24'sh800000;
    return q[SMP_W-1:0];
  endfunction

endpackage

[hdl/lpl_if.sv]
// Valid/ready channel interfaces for input frames and limited output frames.
interface lpl_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [23:0]      left_sample;
  logic signed [23:0]      right_sample;
  modport source (output valid, left_sample, right_sample, input ready);
  modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface lpl_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [23:0]      left_out;
  logic signed [23:0]      right_out;
  logic [23:0]             gain_now;
  modport source (output valid, left_out, right_out, gain_now, input ready);
  modport sink   (input valid, left_out, right_out, gain_now, output ready);
endinterface

[hdl/lpl_lane.sv]
// One channel lane: delay memory with registered read and a running peak magnitude.
module lpl_lane #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpl_pkg::lane_ctl_t         ctl,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [23:0]         wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [23:0]         rd_data,
  output logic [23:0]                peak
);

  logic signed [23:0] mem [DEPTH];
  logic signed [23:0] rd_data_r;
  logic [23:0]        peak_r;
  logic [23:0]        peak_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    peak_nxt = peak_r;
    if (ctl.acc_clr) begin
      peak_nxt = '0;
    end else if (ctl.acc_en && (lpl_pkg::mag24(rd_data_r) > peak_r)) begin
      peak_nxt = lpl_pkg::mag24(rd_data_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= '0;
    end else begin
      peak_r <= peak_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign peak    = peak_r;

endmodule

[hdl/lpl_tpeak.sv]
// Iterative Catmull-Rom true peak: one interpolation point per cycle.
module lpl_tpeak (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [23:0]                 y0,
  input  logic signed [23:0]                 y1,
  input  logic signed [23:0]                 y2,
  input  logic signed [23:0]                 y3,
  output logic                               done,
  output logic [lpl_pkg::PEAK_W-1:0]         peak
);

  localparam int NW = lpl_pkg::NUM_W;

  logic signed [24:0] a_r;
  logic signed [27:0] b_r;
  logic signed [26:0] c_r;
  logic signed [23:0] y1_r;
  logic [lpl_pkg::S_W-1:0]    s_r;
  logic                       busy_r;
  logic                       done_r;
  logic [lpl_pkg::PEAK_W-1:0] best_r;

  logic [6:0]          w1, w2, w3;
  logic signed [7:0]   w1_s, w2_s, w3_s;
  logic signed [NW-1:0] num;
  logic [NW-1:0]       num_abs;
  logic [lpl_pkg::PEAK_W-1:0] m;

  always_comb begin
    w1   = 7'(s_r * lpl_pkg::OVS * lpl_pkg::OVS);
    w2   = 7'(s_r * s_r * lpl_pkg::OVS);
    w3   = 7'(s_r * s_r * s_r);
    w1_s = {1'b0, w1};
    w2_s = {1'b0, w2};
    w3_s = {1'b0, w3};
    num  = (NW'(y1_r) <<< lpl_pkg::TP_SHIFT) + NW'(a_r) * NW'(w1_s)
         + NW'(b_r) * NW'(w2_s) + NW'(c_r) * NW'(w3_s);
    num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    m = lpl_pkg::PEAK_W'(num_abs >> lpl_pkg::TP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= 25'(y2) - 25'(y0);
      b_r  <= (28'(y0) <<< 1) - 28'(y1) * 28'sd5 + (28'(y2) <<< 2) - 28'(y3);
      c_r  <= 27'(y1) * 27'sd3 - 27'(y0) - 27'(y2) * 27'sd3 + 27'(y3);
      y1_r <= y1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      s_r    <= '0;
      best_r <= '0;
    end else begin
      done_r <= busy_r && (32'(s_r) == lpl_pkg::OVS - 1);
      if (start) begin
        busy_r <= 1'b1;
        s_r    <= '0;
        best_r <= '0;
      end else if (busy_r) begin
        if (m > best_r) begin
          best_r <= m;
        end
        s_r <= s_r + 1'b1;
        if (32'(s_r) == lpl_pkg::OVS - 1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign peak = best_r;

endmodule

[hdl/lpl_div.sv]
// Restoring divider for the target gain: threshold * 2^23 / peak, one bit per cycle.
module lpl_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [23:0]                        thr,
  input  logic [lpl_pkg::PEAK_W-1:0]         divisor,
  output logic                               done,
  output logic [lpl_pkg::QUO_W-1:0]          quo
);

  localparam int PW = lpl_pkg::PEAK_W;

  logic [PW-1:0]                 rem_r;
  logic [PW-1:0]                 div_r;
  logic [lpl_pkg::QUO_W-1:0]     quo_r;
  logic [lpl_pkg::DCNT_W-1:0]    cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [PW+1:0]                 trial;

  // The threshold is already below the divisor, so it seeds the remainder directly.
  assign trial = {1'b0, rem_r, 1'b0} - {2'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (32'(cnt_r) == lpl_pkg::QUO_W - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= PW'(thr);
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      if (!trial[PW+1]) begin
        rem_r <= trial[PW-1:0];
        quo_r <= {quo_r[lpl_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[PW-2:0], 1'b0};
        quo_r <= {quo_r[lpl_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[hdl/lookahead_peak_limiter_top.sv]
// Top level of the lookahead peak limiter: control, peak merge, smoothing and gain apply.
//
//  channel  | direction | handshake          | payload
//  in_ch    | sink      | valid/ready        | left_sample, right_sample (Q1.23)
//  out_ch   | source    | valid/ready        | left_out, right_out (Q1.23), gain_now (Q2.22)
//  cfg_*    | sink      | cfg_we, no backoff | cfg_idx selects register, cfg_wdata
//
// A mono transaction runs: accept, len + 3 scan reads through the single read port,
// drain, true peak, divide, then smoothing and multiply. Stereo skips the true peak;
// a peak at or below twice the threshold skips the divide.
// After reset a clearing pass zeroes the delay lines, in_ch.ready low.
// The output register frees the core; a result still waiting there holds the last stage.
module lookahead_peak_limiter_top #(
  parameter int LOOKAHEAD_MAX = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lpl_in_if.sink                             in_ch,
  lpl_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lpl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (LOOKAHEAD_MAX > 1) ? $clog2(LOOKAHEAD_MAX) : 1;
  localparam int LW = AW + 1;
  localparam int JW = AW + 2;

  // Configuration registers
  logic [23:0]                     thr_r;
  logic [23:0]                     ceil_r;
  logic [15:0]                     att_r;
  logic [15:0]                     rel_r;
  logic [lpl_pkg::LEN_REG_W-1:0]   la_len_r;
  logic                            stereo_r;

  // Control state
  lpl_pkg::ctl_state_t  state_r, state_nxt;
  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        pos_r;
  logic [JW-1:0]        j_r;
  logic                 rd_vld_r;
  lpl_pkg::rd_tag_t     rd_tag_r, rd_tag_nxt;
  logic [AW-1:0]        rd_r, a2_r, a3_r;

  // Datapath registers
  logic signed [23:0]   dl_r, rr_r, y2_r, y3_r, prevd_r;
  logic [23:0]          gain_r;
  logic [23:0]          target_r;
  logic [15:0]          csel_r;
  logic [39:0]          p1_r;
  logic signed [48:0]   prod_l_r, prod_r_r;
  logic signed [23:0]   out_l_r, out_r_r;
  logic [23:0]          out_g_r;
  logic                 out_valid_r;

  // Derived geometry
  logic [LW-1:0]        len_eff;
  logic [AW-1:0]        pos_eff;
  logic [AW-1:0]        rd_c, a2_c, a3_c;
  logic [LW-1:0]        k2, k3;
  logic [AW-1:0]        rd_addr;
  logic                 accept;
  logic                 load_out;

  // Lane connections
  lpl_pkg::lane_ctl_t   ctl_l, ctl_r;
  logic [AW-1:0]        wr_addr;
  logic signed [23:0]   wr_l, wr_r;
  logic signed [23:0]   rdat_l, rdat_r;
  logic [23:0]          peak_l, peak_r;

  // Merge, divide and smoothing
  logic                 tp_start, tp_done;
  logic [lpl_pkg::PEAK_W-1:0] tp_peak;
  logic [lpl_pkg::PEAK_W-1:0] peak_m;
  logic                 div_start, div_done;
  logic [lpl_pkg::QUO_W-1:0]  div_quo;
  logic [24:0]          thr2;
  logic [15:0]          csel;
  logic [40:0]          p2;
  logic [41:0]          gsum;
  logic [25:0]          graw;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [LW-1:0] k,
                                             input logic [LW-1:0] len);
    logic [LW:0] s;
    s = (LW+1)'(base) + (LW+1)'(k);
    if (s >= (LW+1)'(len)) s = s - (LW+1)'(len);
    return AW'(s);
  endfunction

  // Clamp the active length into 1..LOOKAHEAD_MAX.
  always_comb begin
    if (la_len_r == '0) begin
      len_eff = LW'(1);
    end else if (32'(la_len_r) > LOOKAHEAD_MAX) begin
      len_eff = LW'(LOOKAHEAD_MAX);
    end else begin
      len_eff = LW'(la_len_r);
    end
    pos_eff = (LW'(pos_r) < len_eff) ? pos_r : '0;
    rd_c    = (LW'(pos_eff) + LW'(1) == len_eff) ? '0 : AW'(LW'(pos_eff) + LW'(1));
    k2      = (len_eff > LW'(1)) ? LW'(1) : LW'(0);
    k3      = (len_eff > LW'(2)) ? LW'(2) : (len_eff - LW'(1));
    a2_c    = wrap_add(rd_c, k2, len_eff);
    a3_c    = wrap_add(rd_c, k3, len_eff);
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == lpl_pkg::S_DONE) && (!out_valid_r || out_ch.ready);

  // Scan order: the whole window for the peak, then the delayed entry and its neighbors.
  always_comb begin
    if (j_r < JW'(len_eff)) begin
      rd_addr    = j_r[AW-1:0];
      rd_tag_nxt = lpl_pkg::TAG_PEAK;
    end else if (j_r == JW'(len_eff)) begin
      rd_addr    = rd_r;
      rd_tag_nxt = lpl_pkg::TAG_DL;
    end else if (j_r == JW'(len_eff) + JW'(1)) begin
      rd_addr    = a2_r;
      rd_tag_nxt = lpl_pkg::TAG_Y2;
    end else begin
      rd_addr    = a3_r;
      rd_tag_nxt = lpl_pkg::TAG_Y3;
    end
  end

  // Lane controls: sweep zeros while clearing, write the new frame on accept (right lane only in stereo).
  always_comb begin
    wr_addr = (state_r == lpl_pkg::S_CLEAR) ? clr_cnt_r : pos_eff;
    wr_l    = (state_r == lpl_pkg::S_CLEAR) ? '0 : in_ch.left_sample;
    wr_r    = (state_r == lpl_pkg::S_CLEAR) ? '0 : in_ch.right_sample;
    ctl_l.wr_en   = (state_r == lpl_pkg::S_CLEAR) || accept;
    ctl_l.acc_clr = accept;
    ctl_l.acc_en  = rd_vld_r && (rd_tag_r == lpl_pkg::TAG_PEAK);
    ctl_r.wr_en   = (state_r == lpl_pkg::S_CLEAR) || (accept && stereo_r);
    ctl_r.acc_clr = accept;
    ctl_r.acc_en  = rd_vld_r && (rd_tag_r == lpl_pkg::TAG_PEAK);
  end

  lpl_lane #(.DEPTH(LOOKAHEAD_MAX), .AW(AW)) u_lane_l (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_l), .wr_addr(wr_addr), .wr_data(wr_l),
    .rd_addr(rd_addr), .rd_data(rdat_l), .peak(peak_l)
  );

  lpl_lane #(.DEPTH(LOOKAHEAD_MAX), .AW(AW)) u_lane_r (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_r), .wr_addr(wr_addr), .wr_data(wr_r),
    .rd_addr(rd_addr), .rd_data(rdat_r), .peak(peak_r)
  );

  lpl_tpeak u_tpeak (
    .clk(clk), .rst_n(rst_n), .start(tp_start),
    .y0(prevd_r), .y1(dl_r), .y2(y2_r), .y3(y3_r),
    .done(tp_done), .peak(tp_peak)
  );

  // Merge lane peaks (the right lane only in stereo); the true peak only counts in mono.
  always_comb begin
    peak_m = lpl_pkg::PEAK_W'(peak_l);
    if (stereo_r && (lpl_pkg::PEAK_W'(peak_r) > peak_m)) begin
      peak_m = lpl_pkg::PEAK_W'(peak_r);
    end
    if (!stereo_r && (tp_peak > peak_m)) begin
      peak_m = tp_peak;
    end
    thr2 = {thr_r, 1'b0};
  end

  lpl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .thr(thr_r),
    .divisor(peak_m), .done(div_done), .quo(div_quo)
  );

  // Smoothing arithmetic
  always_comb begin
    csel = (target_r < gain_r) ? att_r : rel_r;
    p2   = 41'((17'd65536 - {1'b0, csel_r}) * target_r);
    gsum = 42'(p1_r) + 42'(p2) + 42'd32768;
    graw = gsum[41:16];
  end

  // Next state and strobes
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    tp_start    = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      lpl_pkg::S_CLEAR: begin
        if (32'(clr_cnt_r) == LOOKAHEAD_MAX - 1) state_nxt = lpl_pkg::S_IDLE;
      end
      lpl_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = lpl_pkg::S_SCAN;
      end
      lpl_pkg::S_SCAN: begin
        if (j_r == JW'(len_eff) + JW'(2)) state_nxt = lpl_pkg::S_DRAIN;
      end
      lpl_pkg::S_DRAIN: begin
        state_nxt = stereo_r ? lpl_pkg::S_DIVGO : lpl_pkg::S_TPGO;
      end
      lpl_pkg::S_TPGO: begin
        tp_start  = 1'b1;
        state_nxt = lpl_pkg::S_TP;
      end
      lpl_pkg::S_TP: begin
        if (tp_done) state_nxt = lpl_pkg::S_DIVGO;
      end
      lpl_pkg::S_DIVGO: begin
        if ({1'b0, peak_m} <= {2'b0, thr2}) begin
          state_nxt = lpl_pkg::S_SM1;
        end else begin
          div_start = 1'b1;
          state_nxt = lpl_pkg::S_DIV;
        end
      end
      lpl_pkg::S_DIV: begin
        if (div_done) state_nxt = lpl_pkg::S_SM1;
      end
      lpl_pkg::S_SM1:  state_nxt = lpl_pkg::S_SM2;
      lpl_pkg::S_SM2:  state_nxt = lpl_pkg::S_MUL;
      lpl_pkg::S_MUL:  state_nxt = lpl_pkg::S_DONE;
      lpl_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) state_nxt = lpl_pkg::S_IDLE;
      end
      default: state_nxt = lpl_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpl_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      j_r         <= '0;
      rd_vld_r    <= 1'b0;
      rd_tag_r    <= lpl_pkg::TAG_PEAK;
      out_valid_r <= 1'b0;
      gain_r      <= lpl_pkg::UNITY_GAIN;
      prevd_r     <= '0;
      pos_r       <= '0;
      thr_r       <= lpl_pkg::RST_THRESHOLD;
      ceil_r      <= lpl_pkg::RST_CEILING;
      att_r       <= lpl_pkg::RST_ATTACK;
      rel_r       <= lpl_pkg::RST_RELEASE;
      la_len_r    <= lpl_pkg::RST_LEN;
      stereo_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == lpl_pkg::S_SCAN);
      rd_tag_r <= rd_tag_nxt;
      if (state_r == lpl_pkg::S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (accept) begin
        j_r <= '0;
      end else if (state_r == lpl_pkg::S_SCAN) begin
        j_r <= j_r + 1'b1;
      end
      // Commit the new gain, history sample and write position.
      if (state_r == lpl_pkg::S_SM2) begin
        gain_r  <= (graw > 26'(ceil_r)) ? ceil_r : graw[23:0];
        prevd_r <= dl_r;
        pos_r   <= rd_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (lpl_pkg::cfg_idx_t'(cfg_idx))
          lpl_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata[23:0];
          lpl_pkg::CFG_CEILING:   ceil_r <= cfg_wdata[23:0];
          lpl_pkg::CFG_ATTACK:    att_r  <= cfg_wdata[15:0];
          lpl_pkg::CFG_RELEASE:   rel_r  <= cfg_wdata[15:0];
          lpl_pkg::CFG_LOOKAHEAD: begin
            la_len_r <= cfg_wdata[lpl_pkg::LEN_REG_W-1:0];
            pos_r    <= '0;
          end
          lpl_pkg::CFG_STEREO:    stereo_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= rd_c;
      a2_r <= a2_c;
      a3_r <= a3_c;
    end
    if (rd_vld_r) begin
      case (rd_tag_r)
        lpl_pkg::TAG_DL: begin
          dl_r <= rdat_l;
          rr_r <= rdat_r;
        end
        lpl_pkg::TAG_Y2: y2_r <= rdat_l;
        lpl_pkg::TAG_Y3: y3_r <= rdat_l;
        default: ;
      endcase
    end
    if (state_r == lpl_pkg::S_DIVGO) begin
      target_r <= lpl_pkg::UNITY_GAIN;
    end else if (div_done) begin
      target_r <= 24'(div_quo);
    end
    if (state_r == lpl_pkg::S_SM1) begin
      csel_r <= csel;
      p1_r   <= 40'(csel * gain_r);
    end
    if (state_r == lpl_pkg::S_MUL) begin
      prod_l_r <= 49'(dl_r) * 49'($signed({1'b0, gain_r}));
      prod_r_r <= 49'(rr_r) * 49'($signed({1'b0, gain_r}));
    end
    if (load_out) begin
      out_l_r <= lpl_pkg::gain_sat(prod_l_r);
      out_r_r <= stereo_r ? lpl_pkg::gain_sat(prod_r_r) : '0;
      out_g_r <= gain_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_l_r;
  assign out_ch.right_out = out_r_r;
  assign out_ch.gain_now  = out_g_r;

`ifndef SYNTHESIS
  // A taken transaction always starts the window scan.
  a_accept_scan : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == lpl_pkg::S_SCAN))
    else $error("accepted transaction did not start the scan");

  // Division only runs above twice the threshold, so the quotient stays below unity.
  a_quo_bound : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_quo[lpl_pkg::QUO_W-1])
    else $error("target gain quotient out of range");

  // Hold off input while the delay memories are being cleared.
  a_clear_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpl_pkg::S_CLEAR) |-> !in_ch.ready)
    else $error("input taken during clearing pass");
`endif

endmodule

[test/lpl_limiter_checker.sv]
// Checker for the lookahead peak limiter: predicts each limited frame and compares it.
module lpl_limiter_checker (
  input  logic        clk,
  input  logic        rst_n,
  lpl_in_if           in_ch,
  lpl_out_if          out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [23:0] cfg_wdata,
  output int          mismatch_cnt,
  output int          frames_pending
);

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic [23:0]        gain;
  } frame_t;

  frame_t limited_q[$];

  logic [23:0] threshold, ceiling;
  logic [15:0] attack, release_c;
  logic [6:0]  la_len;
  logic        stereo;

  logic signed [23:0] left_line [64];
  logic signed [23:0] right_line [64];
  int unsigned        wr_pos;
  logic [23:0]        gain_state;
  logic signed [23:0] prev_delayed;

  function automatic longint absval(input longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [23:0] scale_sample(input logic signed [23:0] x,
                                                     input logic [23:0] g);
    longint q;
    q = (longint'(x) * longint'(g) + 64'sd2097152) >>> 22;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[23:0];
  endfunction

  function automatic frame_t limit_frame(input logic signed [23:0] l,
                                         input logic signed [23:0] r);
    int unsigned len, pos, rdx, k2, k3;
    longint peak, m, y0, y1, y2, y3, a, b, c, num, tgt, coef, g;
    frame_t f;
    len = la_len == 0 ? 1 : (la_len > 64 ? 64 : la_len);
    pos = wr_pos < len ? wr_pos : 0;
    left_line[pos] = l;
    if (stereo) right_line[pos] = r;
    peak = 0;
    for (int j = 0; j < len; j++) begin
      m = absval(left_line[j]);
      if (m > peak) peak = m;
      if (stereo) begin
        m = absval(right_line[j]);
        if (m > peak) peak = m;
      end
    end
    rdx = (pos + 1) % len;
    if (!stereo) begin
      // Catmull-Rom points between the delayed sample and its successor.
      k2 = (len - 1) < 1 ? len - 1 : 1;
      k3 = (len - 1) < 2 ? len - 1 : 2;
      y0 = prev_delayed;
      y1 = left_line[rdx];
      y2 = left_line[(rdx + k2) % len];
      y3 = left_line[(rdx + k3) % len];
      a = y2 - y0;
      b = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c = -y0 + 3 * y1 - 3 * y2 + y3;
      for (longint s = 0; s < 4; s++) begin
        num = 2 * y1 * 64 + a * s * 16 + b * s * s * 4 + c * s * s * s;
        m = absval(num) / 128;
        if (m > peak) peak = m;
      end
    end
    if (peak <= 2 * longint'(threshold)) tgt = 4194304;
    else tgt = (longint'(threshold) << 23) / peak;
    coef = tgt < gain_state ? attack : release_c;
    g = (coef * gain_state + (65536 - coef) * tgt + 32768) >>> 16;
    if (g > ceiling) g = ceiling;
    gain_state = g[23:0];
    f.left = scale_sample(left_line[rdx], gain_state);
    f.right = stereo ? scale_sample(right_line[rdx], gain_state) : '0;
    f.gain = gain_state;
    prev_delayed = left_line[rdx];
    wr_pos = (pos + 1) % len;
    return f;
  endfunction

  always @(posedge clk) begin
    frame_t want;
    if (!rst_n) begin
      threshold = lpl_pkg::RST_THRESHOLD;
      ceiling = lpl_pkg::RST_CEILING;
      attack = lpl_pkg::RST_ATTACK;
      release_c = lpl_pkg::RST_RELEASE;
      la_len = lpl_pkg::RST_LEN;
      stereo = 1'b0;
      for (int j = 0; j < 64; j++) begin
        left_line[j] = '0;
        right_line[j] = '0;
      end
      wr_pos = 0;
      gain_state = lpl_pkg::UNITY_GAIN;
      prev_delayed = '0;
      limited_q.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (lpl_pkg::cfg_idx_t'(cfg_idx))
          lpl_pkg::CFG_THRESHOLD: threshold = cfg_wdata;
          lpl_pkg::CFG_CEILING:   ceiling = cfg_wdata;
          lpl_pkg::CFG_ATTACK:    attack = cfg_wdata[15:0];
          lpl_pkg::CFG_RELEASE:   release_c = cfg_wdata[15:0];
          lpl_pkg::CFG_LOOKAHEAD: begin
            la_len = cfg_wdata[6:0];
            wr_pos = 0;
          end
          lpl_pkg::CFG_STEREO:    stereo = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (limited_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected output frame L=%0d R=%0d G=%0d",
                     out_ch.left_out, out_ch.right_out, out_ch.gain_now);
        end else begin
          want = limited_q.pop_front();
          if (out_ch.left_out !== want.left || out_ch.right_out !== want.right ||
              out_ch.gain_now !== want.gain) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("frame mismatch: expected L=%0d R=%0d G=%0d, got L=%0d R=%0d G=%0d",
                       want.left, want.right, want.gain,
                       out_ch.left_out, out_ch.right_out, out_ch.gain_now);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        limited_q.push_back(limit_frame(in_ch.left_sample, in_ch.right_sample));
    end
    frames_pending = limited_q.size();
  end
endmodule

[test/tb_lookahead_peak_limiter_top.sv]
// Testbench top for the lookahead peak limiter: stimulus, handshake pressure and verdict.
module tb_lookahead_peak_limiter_top;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_wdata = '0;
  int          mismatch_cnt;
  int          frames_pending;

  // Pressure controls for the sender and the receiver.
  logic quiet = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int   hold_cnt = 0;
  int   amp_shift = 0;

  lpl_in_if  in_ch();
  lpl_out_if out_ch();

  lookahead_peak_limiter_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  lpl_limiter_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .mismatch_cnt(mismatch_cnt), .frames_pending(frames_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.left_sample = '0;
    in_ch.right_sample = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (long_hold_req && !long_hold_done) begin
      // Hold off long enough that the core fills and drops in_ch.ready.
      out_ch.ready <= 1'b0;
      hold_cnt <= 400;
      long_hold_done <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hand one frame to the block; hold valid until the transaction completes.
  task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r);
    bit taken;
    in_ch.valid <= 1'b1;
    in_ch.left_sample <= l;
    in_ch.right_sample <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Write one register, then drop cfg_we again before the next write.
  task automatic write_reg(input lpl_pkg::cfg_idx_t idx, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the sender until every result is back, then let the core settle.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_sample();
    logic signed [23:0] s;
    s = 24'($urandom());
    return s >>> amp_shift;
  endfunction

  task automatic run_phase(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      // Mostly ordinary audio content, now and then a full-scale spike.
      if ($urandom_range(0, 15) == 0)
        send_frame($urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000, 24'($urandom()));
      else
        send_frame(rand_sample(), rand_sample());
    end
  endtask

  initial begin
    logic signed [23:0] edge_vals[6];
    logic [23:0]        thr;
    edge_vals = '{24'sh800000, 24'sh7fffff, 24'sh000000, 24'shffffff,
                  24'sh000001, 24'sh400000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: mono, lookahead 4, otherwise reset settings, full-scale extremes.
    write_reg(lpl_pkg::CFG_ATTACK, 24'd0);
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 24'd4);
    foreach (edge_vals[i]) send_frame(edge_vals[i], edge_vals[5 - i]);
    drain_block();

    // Directed: linked stereo, zero threshold, length 1, slow release.
    write_reg(lpl_pkg::CFG_STEREO, 24'd1);
    write_reg(lpl_pkg::CFG_THRESHOLD, 24'd0);
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 24'd1);
    write_reg(lpl_pkg::CFG_RELEASE, 24'd65535);
    write_reg(lpl_pkg::CFG_CEILING, 24'hffffff);
    foreach (edge_vals[i]) send_frame(edge_vals[5 - i], edge_vals[i]);
    send_frame(24'sh0, 24'sh0);
    drain_block();

    // Directed: out-of-range lengths (0 acts as 1, above 64 as 64), unknown index.
    write_reg(lpl_pkg::CFG_STEREO, 24'd0);
    write_reg(lpl_pkg::CFG_THRESHOLD, 24'd1048576);
    write_reg(lpl_pkg::CFG_RELEASE, 24'd0);
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 24'd0);
    cfg_we <= 1'b1;
    cfg_idx <= 3'd7;
    cfg_wdata <= 24'hffffff;
    @(posedge clk);
    cfg_we <= 1'b0;
    send_frame(24'sh7fffff, 24'sh1);
    send_frame(24'sh800000, 24'sh1);
    send_frame(24'sh7fffff, 24'sh1);
    drain_block();
    write_reg(lpl_pkg::CFG_LOOKAHEAD, 24'd127);
    for (int i = 0; i < 6; i++) send_frame(edge_vals[i], edge_vals[i]);
    drain_block();

    // Random phases with varied settings; extremes included on the way.
    for (int ph = 0; ph < 12; ph++) begin
      thr = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 24'hffffff : 24'd0)
                                        : 24'($urandom_range(1 << 18, 1 << 23));
      write_reg(lpl_pkg::CFG_THRESHOLD, thr);
      write_reg(lpl_pkg::CFG_CEILING,
                ph == 3 ? 24'd0 : (ph % 2 ? 24'hffffff : 24'($urandom())));
      write_reg(lpl_pkg::CFG_ATTACK, ph == 5 ? 24'd65535 : 24'($urandom_range(0, 65535)));
      write_reg(lpl_pkg::CFG_RELEASE, ph == 6 ? 24'd0 : 24'($urandom_range(40000, 65535)));
      // Keep windows short most of the time; a few phases use the full depth.
      write_reg(lpl_pkg::CFG_LOOKAHEAD,
                (ph % 4 == 2) ? 24'd64 : 24'($urandom_range(1, 9)));
      write_reg(lpl_pkg::CFG_STEREO, 24'(ph % 2));
      amp_shift = $urandom_range(0, 3);
      if (ph == 4) long_hold_req <= 1'b1;
      if (ph == 11) quiet <= 1'b1;
      run_phase(125);
      drain_block();
    end

    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && frames_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(12 * 1500000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

[lookahead_peak_limiter_top.f]
hdl/lpl_pkg.sv
hdl/lpl_if.sv
hdl/lpl_lane.sv
hdl/lpl_tpeak.sv
hdl/lpl_div.sv
hdl/lookahead_peak_limiter_top.sv
test/lpl_limiter_checker.sv
test/tb_lookahead_peak_limiter_top.sv
